### sv/lth_pkg.sv
// ---------------------------------------------------------------------------
// Tiered latency histogram package
// Shared types, codes and constants for the tiered latency histogram.
// ---------------------------------------------------------------------------
`default_nettype none

package lth_pkg;

   // Counter width; counters wrap at this width.
   localparam int COUNT_BITS = 32;

   // Bin store layout.
   localparam int NUM_BINS      = 162;
   localparam int BIN_ADDR_BITS = $clog2(NUM_BINS);
   localparam int TOTAL_INDEX   = 162;

   localparam logic [7:0] USEC_BASE    = 8'd1;
   localparam logic [7:0] MSEC_BASE    = 8'd101;
   localparam logic [7:0] HALFSEC_BASE = 8'd151;
   localparam logic [7:0] WAYOUT_BIN   = 8'd161;

   // Tier limits in nanoseconds.
   localparam logic [63:0] LIMIT_USEC    = 64'd1000;
   localparam logic [63:0] LIMIT_MSEC    = 64'd1000000;
   localparam logic [63:0] LIMIT_50MSEC  = 64'd50000000;
   localparam logic [63:0] LIMIT_5SEC    = 64'd5000000000;

   // Operation codes.
   localparam logic [1:0] FUNC_RECORD = 2'd0;
   localparam logic [1:0] FUNC_READ   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] sample_ns;
      logic [7:0]  read_index;
   } lth_req_type;

   typedef struct packed {
      logic [7:0]  bin_hit;
      logic [31:0] count_value;
   } lth_rsp_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_CALC,
      ST_LOOKUP,
      ST_UPDATE
   } lth_state_type;

endpackage

`default_nettype wire

### sv/lth_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module lth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 162
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### sv/lth_bin_map.sv
// ---------------------------------------------------------------------------
// Tiered latency histogram bin mapper
// Maps a latency in nanoseconds to its bin. The tier quotients come from
// reciprocal multiplications that are exact over each tier's range; the
// products and tier flags are registered, so the bin is valid in the cycle
// after the sample.
// ---------------------------------------------------------------------------
`default_nettype none

module lth_bin_map (
   input  wire logic        clock,
   input  wire logic [63:0] sample_ns,
   output      logic [7:0]  bin
);

   import lth_pkg::*;

   // Reciprocals: ns / 10000 for ns below 2^20, ns / 1e6 for ns below 2^26,
   // (ns >> 8) / 1953125 (that is ns / 5e8) for ns below 2^33.
   localparam logic [20:0] RECIP_10US  = 21'd1717987;
   localparam logic [26:0] RECIP_1MS   = 27'd70368745;
   localparam logic [25:0] RECIP_500MS = 26'd36028798;

   logic [40:0] prod_us;
   logic [52:0] prod_ms;
   logic [50:0] prod_hs;

   logic [6:0] q_us_ff;
   logic [5:0] q_ms_ff;
   logic [3:0] q_hs_ff;
   logic       lt_usec_ff;
   logic       lt_msec_ff;
   logic       lt_50msec_ff;
   logic       lt_5sec_ff;

   // Reciprocal products.
   always_comb begin
      prod_us = 41'(sample_ns[19:0]) * 41'(RECIP_10US);
      prod_ms = 53'(sample_ns[25:0]) * 53'(RECIP_1MS);
      prod_hs = 51'(sample_ns[32:8]) * 51'(RECIP_500MS);
   end

   // Quotient and tier flag registers.
   always_ff @(posedge clock) begin
      q_us_ff      <= prod_us[40:34];
      q_ms_ff      <= prod_ms[51:46];
      q_hs_ff      <= prod_hs[49:46];
      lt_usec_ff   <= sample_ns < LIMIT_USEC;
      lt_msec_ff   <= sample_ns < LIMIT_MSEC;
      lt_50msec_ff <= sample_ns < LIMIT_50MSEC;
      lt_5sec_ff   <= sample_ns < LIMIT_5SEC;
   end

   // Tier selection.
   always_comb begin
      if (lt_usec_ff) begin
         bin = 8'd0;
      end else if (lt_msec_ff) begin
         bin = USEC_BASE + 8'(q_us_ff);
      end else if (lt_50msec_ff) begin
         bin = MSEC_BASE + 8'(q_ms_ff);
      end else if (lt_5sec_ff) begin
         bin = HALFSEC_BASE + 8'(q_hs_ff);
      end else begin
         bin = WAYOUT_BIN;
      end
   end

endmodule

`default_nettype wire

### sv/latency_tiered_histogram.sv
// ---------------------------------------------------------------------------
// Tiered latency histogram
// Record and read requests pass through bin mapping, RAM read and
// write-back over the single RAM; the response strobe comes as the block
// returns to idle, and no new request is taken until then.
// A clear request sweeps the 162-entry RAM one entry a cycle and strobes a
// response once the last entry is written; then the next request is taken.
// Reset starts the same clearing pass; busy is high meanwhile.
// Responses are strobed for one cycle; the receiver cannot stall.
// ---------------------------------------------------------------------------
`default_nettype none

module latency_tiered_histogram (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire lth_pkg::lth_req_type req_item,
   output      logic                 rsp_valid,
   output      lth_pkg::lth_rsp_type rsp_item
);

   import lth_pkg::*;

   lth_state_type state_ff, state_in;
   logic [BIN_ADDR_BITS-1:0] sweep_ff, sweep_in;
   logic sweep_cmd_ff, sweep_cmd_in;
   logic rsp_valid_ff, rsp_valid_in;

   lth_req_type req_ff, req_in;
   lth_rsp_type rsp_ff, rsp_in;
   logic [7:0] bin_ff, bin_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;

   logic [7:0] map_bin;
   logic [7:0] target;
   logic [COUNT_BITS-1:0] bumped;

   logic mem_we;
   logic [BIN_ADDR_BITS-1:0] mem_waddr;
   logic [BIN_ADDR_BITS-1:0] mem_raddr;
   logic [COUNT_BITS-1:0] mem_wdata;
   logic [COUNT_BITS-1:0] mem_rdata;

   lth_bin_map u_bin_map (
      .clock     (clock),
      .sample_ns (req_ff.sample_ns),
      .bin       (map_bin)
   );

   lth_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_BINS)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         sweep_cmd_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_cmd_ff <= sweep_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers. The total is zeroed by the clearing pass.
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      bin_ff   <= bin_in;
      total_ff <= total_in;
   end

   // Sequencer: sweep, accept, map, read, then modify and write back.
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      sweep_cmd_in = sweep_cmd_ff;
      rsp_valid_in = 1'b0;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      bin_in       = bin_ff;
      total_in     = total_ff;
      mem_we       = 1'b0;
      mem_waddr    = bin_ff[BIN_ADDR_BITS-1:0];
      mem_wdata    = '0;
      target       = (req_ff.func == FUNC_RECORD) ? map_bin : req_ff.read_index;
      mem_raddr    = target[BIN_ADDR_BITS-1:0];
      bumped       = mem_rdata + COUNT_BITS'(1);

      case (state_ff)
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            total_in  = '0;
            if (sweep_ff == BIN_ADDR_BITS'(NUM_BINS - 1)) begin
               state_in     = ST_IDLE;
               sweep_in     = '0;
               sweep_cmd_in = 1'b0;
               if (sweep_cmd_ff) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.bin_hit      = 8'd0;
                  rsp_in.count_value  = 32'd0;
               end
            end else begin
               sweep_in = sweep_ff + BIN_ADDR_BITS'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               if (req_item.func == FUNC_CLEAR) begin
                  state_in     = ST_SWEEP;
                  sweep_in     = '0;
                  sweep_cmd_in = 1'b1;
               end else begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            // The bin mapper registers the sample during this cycle.
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            bin_in   = target;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            case (req_ff.func)
               FUNC_RECORD: begin
                  mem_we             = 1'b1;
                  mem_wdata          = bumped;
                  total_in           = total_ff + COUNT_BITS'(1);
                  rsp_in.bin_hit     = bin_ff;
                  rsp_in.count_value = 32'(bumped);
               end
               FUNC_READ: begin
                  rsp_in.bin_hit = bin_ff;
                  if (bin_ff < 8'(NUM_BINS)) begin
                     rsp_in.count_value = 32'(mem_rdata);
                  end else if (bin_ff == 8'(TOTAL_INDEX)) begin
                     rsp_in.count_value = 32'(total_ff);
                  end else begin
                     rsp_in.count_value = 32'd0;
                  end
               end
               default: begin
                  rsp_in.bin_hit     = 8'd0;
                  rsp_in.count_value = 32'd0;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire
